// File: hdl/fdwd_pkg.sv
package fdwd_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int GAIN_FRAC   = 14;
  localparam int DELAY_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int DELAY_W     = 12;
  localparam int WET_W       = 15;
  localparam int FB_W        = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int SAT_W       = 48;

  localparam logic [WET_W-1:0] GAIN_ONE = WET_W'(1 << GAIN_FRAC);
  localparam logic [FB_W-1:0]  FB_RATIO_RESET = FB_W'(1638);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ADDR_W-1:0]          addr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY = 2'd0,
    CFG_WET   = 2'd1,
    CFG_FB    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic    wr_en;
    sample_t wr_data;
    addr_t   delay;
  } dl_req_t;

  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_MAX - SAT_W'(1);

  function automatic sample_t sat_sample(input logic signed [SAT_W-1:0] x);
    sample_t res;
    if (x > SAT_MAX) begin
      res = SAMPLE_W'(SAT_MAX);
    end else if (x < SAT_MIN) begin
      res = SAMPLE_W'(SAT_MIN);
    end else begin
      res = SAMPLE_W'(x);
    end
    return res;
  endfunction

endpackage

// File: hdl/fdwd_delay_line.sv
module fdwd_delay_line
  import fdwd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  dl_req_t req,
  output sample_t rd_data
);

  sample_t mem [DELAY_DEPTH];
  sample_t mem_q;
  sample_t fwd_data_r;
  logic    fwd_r;
  logic    zero_r;
  addr_t   wp_r;
  addr_t   wp_nxt;
  logic    wrapped_r;
  logic    wrapped_nxt;
  addr_t   rd_addr;

  always_comb begin
    if (req.delay > wp_r) begin
      rd_addr = ADDR_W'(int'(wp_r) + DELAY_DEPTH - int'(req.delay));
    end else begin
      rd_addr = wp_r - req.delay;
    end
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    if (req.wr_en) begin
      if (wp_r == ADDR_W'(DELAY_DEPTH - 1)) begin
        wp_nxt      = '0;
        wrapped_nxt = 1'b1;
      end else begin
        wp_nxt = wp_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wp_r] <= req.wr_data;
      mem_q     <= mem[rd_addr];
    end
  end

  // Entries are written in address order from zero, so an entry above the
  // write pointer has never been written until the pointer first wraps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      wrapped_r  <= 1'b0;
      fwd_r      <= 1'b0;
      zero_r     <= 1'b0;
    end else begin
      wp_r      <= wp_nxt;
      wrapped_r <= wrapped_nxt;
      if (req.wr_en) begin
        fwd_r  <= (req.delay == '0);
        zero_r <= !wrapped_r && (req.delay > wp_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      fwd_data_r <= req.wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : (zero_r ? '0 : mem_q);

  a_wp_advance: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en && $past(rst_n) |=> (wp_r == $past(wp_nxt)) && (wp_r != $past(wp_r)))
    else $error("write pointer did not advance on a write");

  a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    wrapped_r |=> wrapped_r)
    else $error("wrap flag cleared outside reset");

endmodule

// File: hdl/feedback_delay_wet_dry.sv
// Feedback delay echo with wet/dry mix.
// An accepted beat steps through the MUL, MIX and FB states; the result is registered
// as FB ends, and FB waits while a pending result is stalled. A new sample is taken
// only in IDLE: the memory read and three multiplies of one sample must finish before
// the next sample's feedback sum. Reset: synchronous active-low; control registers take
// reset values; each delay memory entry reads zero until first written, with no clearing pass.
module feedback_delay_wet_dry
  import fdwd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sample_t               in_sample_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sample_t               out_sample_out,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_MIX  = 4'b0100,
    S_FB   = 4'b1000
  } state_t;

  localparam int WETP_W = WET_W + 1 + SAMPLE_W;
  localparam int FBP_W  = FB_W + 1 + SAMPLE_W;

  state_t                    state_r, state_nxt;
  logic [DELAY_W-1:0]        delay_r;
  logic [WET_W-1:0]          wet_gain_r;
  logic [FB_W-1:0]           fb_ratio_r;
  sample_t                   fb_r;
  sample_t                   v_r;
  sample_t                   wet_r;
  sample_t                   mix_r;
  sample_t                   out_r;
  logic                      out_valid_r;
  logic signed [WETP_W-1:0]  wetp_r;
  logic signed [WETP_W-1:0]  dryp_r;
  logic signed [FBP_W-1:0]   fbp;
  logic [WET_W-1:0]          wet_eff;
  logic [WET_W-1:0]          dry_gain;
  addr_t                     delay_eff;
  sample_t                   v_nxt;
  sample_t                   delayed;
  sample_t                   wet_nxt;
  sample_t                   dry_s;
  logic                      in_acc;
  logic                      out_load;
  dl_req_t                   dl_req;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_FB) && !(out_valid_r && out_stall);

  always_comb begin
    wet_eff  = (wet_gain_r > GAIN_ONE) ? GAIN_ONE : wet_gain_r;
    dry_gain = GAIN_ONE - wet_eff;
    if (int'(delay_r) > DELAY_DEPTH - 1) begin
      delay_eff = ADDR_W'(DELAY_DEPTH - 1);
    end else begin
      delay_eff = ADDR_W'(delay_r);
    end
    v_nxt   = sat_sample(SAT_W'(in_sample_in) + SAT_W'(fb_r));
    wet_nxt = sat_sample(SAT_W'(wetp_r >>> GAIN_FRAC));
    dry_s   = sat_sample(SAT_W'(dryp_r >>> GAIN_FRAC));
    fbp     = $signed({1'b0, fb_ratio_r}) * wet_r;
  end

  assign dl_req = '{wr_en: in_acc, wr_data: v_nxt, delay: delay_eff};

  fdwd_delay_line u_delay (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (dl_req),
    .rd_data (delayed)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_MIX;
      S_MIX:  state_nxt = S_FB;
      S_FB:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      delay_r     <= '0;
      wet_gain_r  <= '0;
      fb_ratio_r  <= FB_RATIO_RESET;
      fb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_DELAY: delay_r    <= cfg_data[DELAY_W-1:0];
          CFG_WET:   wet_gain_r <= cfg_data[WET_W-1:0];
          CFG_FB:    fb_ratio_r <= cfg_data[FB_W-1:0];
          default:   ;
        endcase
      end
      if (out_load) begin
        fb_r        <= sat_sample(SAT_W'(fbp >>> GAIN_FRAC));
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      v_r <= v_nxt;
    end
    if (state_r == S_MUL) begin
      wetp_r <= $signed({1'b0, wet_eff}) * delayed;
      dryp_r <= $signed({1'b0, dry_gain}) * v_r;
    end
    if (state_r == S_MIX) begin
      wet_r <= wet_nxt;
      mix_r <= sat_sample(SAT_W'(wet_nxt) + SAT_W'(dry_s));
    end
    if (out_load) begin
      out_r <= mix_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_MUL)
    else $error("accepted beat did not start processing");

  a_fb_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(fb_r) |-> $past(state_r == S_FB))
    else $error("feedback changed outside the final step");

  a_out_from_fb: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(out_r) |-> $past(state_r == S_FB))
    else $error("result register loaded outside the final step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && (state_r == S_FB) |=> state_r == S_FB)
    else $error("pending result overwritten");

endmodule

// File: test/tb_feedback_delay_wet_dry.sv
`timescale 1ns / 100ps

module tb_feedback_delay_wet_dry;
  import fdwd_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES = 8;
  localparam int PHASE_BEATS = 125;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam longint UNITY = longint'(1) << GAIN_FRAC;
  localparam longint LEVEL_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint LEVEL_MIN = -LEVEL_MAX - 1;
  localparam sample_t PEAK = sample_t'(LEVEL_MAX);
  localparam sample_t TROUGH = sample_t'(LEVEL_MIN);

  class echo_mix_scoreboard;
    sample_t echo_mem [DELAY_DEPTH];
    addr_t wr_ptr;
    longint fb_val;
    logic [DELAY_W-1:0] delay_len;
    logic [WET_W-1:0] wet_gain;
    logic [FB_W-1:0] fb_ratio;
    sample_t mix_due [$];
    int errors;

    function new();
      foreach (echo_mem[i]) echo_mem[i] = '0;
      wr_ptr = '0;
      fb_val = 0;
      delay_len = '0;
      wet_gain = '0;
      fb_ratio = FB_RATIO_RESET;
      errors = 0;
    endfunction

    function longint clip(longint x);
      if (x > LEVEL_MAX) begin
        return LEVEL_MAX;
      end
      if (x < LEVEL_MIN) begin
        return LEVEL_MIN;
      end
      return x;
    endfunction

    // Arithmetic shift of the product drops the fraction bits toward minus infinity.
    function longint scale(longint g, longint x);
      return (g * x) >>> GAIN_FRAC;
    endfunction

    function void report(string msg);
      errors++;
      $display("[%0t] error: %s", $time, msg);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DELAY: delay_len = data[DELAY_W-1:0];
        CFG_WET:   wet_gain = data[WET_W-1:0];
        CFG_FB:    fb_ratio = data[FB_W-1:0];
        default:   ;
      endcase
    endfunction

    function void note_sample(sample_t s);
      longint w;
      longint v;
      longint tap;
      longint wet;
      longint mix;
      addr_t rd;
      w = (longint'(wet_gain) > UNITY) ? UNITY : longint'(wet_gain);
      v = clip(longint'(s) + fb_val);
      echo_mem[wr_ptr] = sample_t'(v);
      rd = wr_ptr - addr_t'(delay_len);
      tap = longint'(echo_mem[rd]);
      wr_ptr = wr_ptr + 1'b1;
      wet = clip(scale(w, tap));
      fb_val = clip(scale(longint'(fb_ratio), wet));
      mix = clip(scale(UNITY - w, v) + wet);
      mix_due.push_back(sample_t'(mix));
    endfunction

    function void check_mix(sample_t got);
      sample_t want;
      if (mix_due.size() == 0) begin
        report($sformatf("sample_out %0d with no result expected", got));
      end else begin
        want = mix_due.pop_front();
        if (got !== want) begin
          report($sformatf("sample_out %0d, expected %0d", got, want));
        end
      end
    endfunction

    function int pending();
      return mix_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sample_t in_sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sample_t out_sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DELAY;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  echo_mix_scoreboard sb = new();
  int in_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  feedback_delay_wet_dry u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
      end
      if (out_valid && !out_stall) begin
        sb.check_mix(out_sample_out);
      end
      if (in_valid && !in_stall) begin
        sb.note_sample(in_sample_in);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  task automatic send_sample(input sample_t s);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic close_burst();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] dly, input logic [CFG_DATA_W-1:0] wet,
                              input logic [CFG_DATA_W-1:0] fb, input bit spare);
    cfg_write(CFG_DELAY, dly);
    cfg_write(CFG_WET, wet);
    cfg_write(CFG_FB, fb);
    if (spare) begin
      cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_delay();
    logic [CFG_DATA_W-1:0] r;
    r = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 5))
      0:       r[DELAY_W-1:0] = '0;
      1:       r[DELAY_W-1:0] = '1;
      2:       r[DELAY_W-1:0] = DELAY_W'($urandom_range(0, 600));
      default: r[DELAY_W-1:0] = DELAY_W'($urandom_range(1, 12));
    endcase
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_wet();
    logic [CFG_DATA_W-1:0] r;
    r = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 4))
      0:       r[WET_W-1:0] = GAIN_ONE;
      1:       r[WET_W-1:0] = '1;
      2:       ;
      default: r[WET_W-1:0] = WET_W'($urandom_range(0, 16384));
    endcase
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_fb();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_DATA_W'(32768);
      2:       return '1;
      3:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(0, 20000));
    endcase
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return PEAK;
      1:       return TROUGH;
      2, 3:    return sample_t'(int'($urandom_range(0, 4095)) - 2048);
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no wet path, so the output is the dry input.
    send_sample(PEAK);
    send_sample(TROUGH);
    send_sample('0);
    send_sample(sample_t'(-1));
    close_burst();

    program_regs(16'd0, 16'd16384, 16'd0, 1'b0);
    send_sample(sample_t'(24'h555555));
    send_sample(sample_t'(24'hAAAAAA));
    send_sample(PEAK);
    close_burst();

    // Wet gain above one, feedback above two, and an unknown register index;
    // repeated full-scale beats overflow the input sum.
    program_regs(16'd1, 16'd32767, 16'hFFFF, 1'b1);
    send_sample(PEAK);
    send_sample(PEAK);
    send_sample(PEAK);
    send_sample(TROUGH);
    send_sample(TROUGH);
    send_sample(TROUGH);
    close_burst();

    program_regs(16'hFFFF, 16'd8192, 16'd16384, 1'b0);
    send_sample(PEAK);
    send_sample(TROUGH);
    send_sample(sample_t'(1));
    send_sample(sample_t'(-2));
    close_burst();

    program_regs(16'd2, 16'd16384, 16'd32768, 1'b0);
    send_sample(PEAK);
    send_sample('0);
    send_sample('0);
    send_sample('0);
    close_burst();

    for (int p = 0; p < PHASES; p++) begin
      program_regs(pick_delay(), pick_wet(), pick_fb(), p == 3);
      case (p % 4)
        0: begin
          in_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          in_idle_pct = 78;
          stall_pct = 0;
        end
        2: begin
          in_idle_pct = 0;
          stall_pct = 78;
        end
        default: begin
          in_idle_pct = 31;
          stall_pct = 31;
        end
      endcase
      if (p == 4) begin
        hold_left = HOLD_CYCLES;
      end
      for (int k = 0; k < PHASE_BEATS; k++) begin
        send_sample(pick_sample());
      end
      close_burst();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/fdwd_pkg.sv
hdl/fdwd_delay_line.sv
hdl/feedback_delay_wet_dry.sv
test/tb_feedback_delay_wet_dry.sv
